// ----- rtl/wctp_pkg.sv -----
// Shared widths, codes and constants for the wall clock tick pacer.
// No dependencies; used by the channel interfaces, the top level and the testbench.
`default_nettype none

package wctp_pkg;

  localparam int unsigned TPS_W      = 40;
  localparam int unsigned CHUNK_W    = 32;
  localparam int unsigned NOW_W      = 63;
  localparam int unsigned CNT_W      = 64;
  localparam int unsigned GRANT_W    = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 40;

  // multiples of one second in ns, for the radix-4 divider digit select
  localparam logic [31:0] NS_X1 = 32'd1000000000;
  localparam logic [31:0] NS_X2 = 32'd2000000000;
  localparam logic [31:0] NS_X3 = 32'd3000000000;

  // sequencer step counts (radix-4 divide consumes 2 bits per step)
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned DIV_NS_STEPS  = 32;
  localparam int unsigned DIV_TPS_STEPS = 20;
  localparam int unsigned DIV_LO_STEPS  = 30;
  localparam int unsigned MUL_STEPS     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_CREDIT = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPS   = 1'b0,
    CFG_CHUNK = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- rtl/wctp_if.sv -----
// Valid/ready channel interfaces of the tick pacer: request, response, config.
// Depends on wctp_pkg for field widths.
`default_nettype none

interface wctp_req_if;
  logic                           valid;
  logic                           ready;
  logic [wctp_pkg::OP_W-1:0]      opcode;
  logic [wctp_pkg::NOW_W-1:0]     now_ns;
  logic [wctp_pkg::CNT_W-1:0]     tick_count;

  modport source (output valid, opcode, now_ns, tick_count, input ready);
  modport sink   (input valid, opcode, now_ns, tick_count, output ready);
endinterface

interface wctp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [wctp_pkg::GRANT_W-1:0]   ticks_granted;

  modport source (output valid, ticks_granted, input ready);
  modport sink   (input valid, ticks_granted, output ready);
endinterface

interface wctp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wctp_pkg::CFG_IDX_W-1:0]   index;
  logic [wctp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/wall_clock_tick_pacer_top.sv -----
// Wall clock tick pacer: start/credit/query sequencer over one shared
// radix-4 divide-by-1e9 unit and one 40x8 multiply-accumulate unit.
// Depends on wctp_pkg and the channel interfaces in wctp_if.sv.
//
//  channel | dir | payload                              | accepted when
//  --------+-----+--------------------------------------+----------------------
//  req_i   | in  | opcode, now_ns, tick_count           | valid & ready
//  rsp_o   | out | ticks_granted                        | valid & ready
//  cfg_i   | in  | index (0 rate, 1 max chunk), data    | valid & ready (ready=1)
//
// Start and credit pass from decode straight to the emit state; a query that
// passes the enable and time checks runs three divide-by-1e9 passes (2 quotient
// bits per step), three multiply passes, then sum, target, lag and grant.
// Ready is high only while the sequencer is idle; one request is in flight.
// A held response does not stop the next request; a finished one waits in
// the emit state until the output register frees. Reset clears all state.
`default_nettype none

module wall_clock_tick_pacer_top (
  input  wire              clk_i,
  input  wire              rst_ni,
  wctp_req_if.sink         req_i,
  wctp_rsp_if.source       rsp_o,
  wctp_cfg_if.sink         cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_NS,
    S_DIV_TPS,
    S_MUL_WHOLE,
    S_MUL_HI,
    S_MUL_LO,
    S_DIV_LO,
    S_SUM,
    S_TARGET,
    S_LAG,
    S_GRANT,
    S_EMIT
  } state_e;

  state_e state_q;

  // config and architectural state
  logic [wctp_pkg::TPS_W-1:0]   tps_q;
  logic [wctp_pkg::CHUNK_W-1:0] chunk_q;
  logic [wctp_pkg::NOW_W-1:0]   origin_q;
  logic [wctp_pkg::CNT_W-1:0]   emitted_q;

  // latched request
  logic [wctp_pkg::OP_W-1:0]    op_q;
  logic [wctp_pkg::NOW_W-1:0]   now_q;
  logic [wctp_pkg::CNT_W-1:0]   cnt_q;

  // shared units
  logic [63:0]                  dvd_q;
  logic [29:0]                  rmd_q;
  logic [79:0]                  acc_q;
  logic [39:0]                  mcand_q;
  logic [39:0]                  mplier_q;
  logic [wctp_pkg::STEP_W-1:0]  step_q;

  // intermediate results
  logic [33:0]                  secs_q;
  logic [29:0]                  rem_q;
  logic [10:0]                  qt_q;
  logic [29:0]                  rt_q;
  logic [63:0]                  whole_q;
  logic                         whole_sat_q;
  logic [40:0]                  frac_hi_q;
  logic [41:0]                  frac_q;
  logic [63:0]                  target_q;
  logic [63:0]                  lag_q;
  logic                         ahead_q;
  logic [wctp_pkg::GRANT_W-1:0] res_q;

  logic                         out_valid_q;
  logic [wctp_pkg::GRANT_W-1:0] out_grant_q;

  // divider step: next 2 quotient bits from {remainder, top dividend bits}
  logic [31:0] div_t;
  logic [1:0]  div_digit;
  logic [31:0] div_sub;
  logic [29:0] rmd_d;
  logic [63:0] dvd_d;

  assign div_t = {rmd_q, dvd_q[63:62]};

  always_comb begin
    priority if (div_t >= wctp_pkg::NS_X3) begin
      div_digit = 2'd3;
      div_sub   = wctp_pkg::NS_X3;
    end else if (div_t >= wctp_pkg::NS_X2) begin
      div_digit = 2'd2;
      div_sub   = wctp_pkg::NS_X2;
    end else if (div_t >= wctp_pkg::NS_X1) begin
      div_digit = 2'd1;
      div_sub   = wctp_pkg::NS_X1;
    end else begin
      div_digit = 2'd0;
      div_sub   = 32'd0;
    end
  end

  logic [31:0] div_diff;
  assign div_diff = div_t - div_sub;
  assign rmd_d    = div_diff[29:0];
  assign dvd_d    = {dvd_q[61:0], div_digit};

  // multiply step: MSB-first byte of the multiplier
  logic [47:0] mul_prod;
  logic [79:0] acc_d;
  logic [39:0] mplier_d;

  assign mul_prod = 48'(mcand_q) * 48'(mplier_q[39:32]);
  assign acc_d    = {acc_q[71:0], 8'd0} + {32'd0, mul_prod};
  assign mplier_d = {mplier_q[31:0], 8'd0};

  logic step_last;
  assign step_last = (step_q == '0);

  logic [62:0] elapsed;
  logic [64:0] credit_sum;
  logic [64:0] target_sum;
  logic [64:0] lag_full;
  logic        over_chunk;
  logic        skip_ahead;

  assign elapsed    = now_q - origin_q;
  assign credit_sum = {1'b0, emitted_q} + {1'b0, cnt_q};
  assign target_sum = {1'b0, whole_q} + {23'd0, frac_q};
  assign lag_full   = {1'b0, target_q} - {1'b0, emitted_q};
  assign over_chunk = lag_q > {32'd0, chunk_q};
  assign skip_ahead = lag_q >= {30'd0, chunk_q, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tps_q       <= '0;
      chunk_q     <= '0;
      origin_q    <= '0;
      emitted_q   <= '0;
      op_q        <= '0;
      now_q       <= '0;
      cnt_q       <= '0;
      dvd_q       <= '0;
      rmd_q       <= '0;
      acc_q       <= '0;
      mcand_q     <= '0;
      mplier_q    <= '0;
      step_q      <= '0;
      secs_q      <= '0;
      rem_q       <= '0;
      qt_q        <= '0;
      rt_q        <= '0;
      whole_q     <= '0;
      whole_sat_q <= 1'b0;
      frac_hi_q   <= '0;
      frac_q      <= '0;
      target_q    <= '0;
      lag_q       <= '0;
      ahead_q     <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_grant_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          wctp_pkg::CFG_TPS:   tps_q   <= cfg_i.data[wctp_pkg::TPS_W-1:0];
          wctp_pkg::CFG_CHUNK: chunk_q <= cfg_i.data[wctp_pkg::CHUNK_W-1:0];
          default: ;
        endcase
      end

      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q    <= req_i.opcode;
            now_q   <= req_i.now_ns;
            cnt_q   <= req_i.tick_count;
            state_q <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_q   <= '0;
          state_q <= S_EMIT;
          unique case (op_q)
            wctp_pkg::OP_START: begin
              origin_q  <= now_q;
              emitted_q <= '0;
            end
            wctp_pkg::OP_CREDIT: begin
              emitted_q <= credit_sum[64] ? '1 : credit_sum[63:0];
            end
            wctp_pkg::OP_QUERY: begin
              if (tps_q != '0 && chunk_q != '0 && now_q > origin_q) begin
                dvd_q   <= {1'b0, elapsed};
                rmd_q   <= '0;
                step_q  <= wctp_pkg::STEP_W'(wctp_pkg::DIV_NS_STEPS - 1);
                state_q <= S_DIV_NS;
              end
            end
            default: ;
          endcase
        end

        S_DIV_NS: begin
          dvd_q  <= dvd_d;
          rmd_q  <= rmd_d;
          step_q <= step_q - 1'b1;
          if (step_last) begin
            secs_q  <= dvd_d[33:0];
            rem_q   <= rmd_d;
            dvd_q   <= {tps_q, 24'd0};
            rmd_q   <= '0;
            step_q  <= wctp_pkg::STEP_W'(wctp_pkg::DIV_TPS_STEPS - 1);
            state_q <= S_DIV_TPS;
          end
        end

        S_DIV_TPS: begin
          dvd_q  <= dvd_d;
          rmd_q  <= rmd_d;
          step_q <= step_q - 1'b1;
          if (step_last) begin
            qt_q     <= dvd_d[10:0];
            rt_q     <= rmd_d;
            mcand_q  <= {6'd0, secs_q};
            mplier_q <= tps_q;
            acc_q    <= '0;
            step_q   <= wctp_pkg::STEP_W'(wctp_pkg::MUL_STEPS - 1);
            state_q  <= S_MUL_WHOLE;
          end
        end

        S_MUL_WHOLE: begin
          acc_q    <= acc_d;
          mplier_q <= mplier_d;
          step_q   <= step_q - 1'b1;
          if (step_last) begin
            whole_sat_q <= |acc_d[79:64];
            whole_q     <= acc_d[63:0];
            mcand_q     <= {10'd0, rem_q};
            mplier_q    <= {29'd0, qt_q};
            acc_q       <= '0;
            step_q      <= wctp_pkg::STEP_W'(wctp_pkg::MUL_STEPS - 1);
            state_q     <= S_MUL_HI;
          end
        end

        S_MUL_HI: begin
          acc_q    <= acc_d;
          mplier_q <= mplier_d;
          step_q   <= step_q - 1'b1;
          if (step_last) begin
            frac_hi_q <= acc_d[40:0];
            mcand_q   <= {10'd0, rem_q};
            mplier_q  <= {10'd0, rt_q};
            acc_q     <= '0;
            step_q    <= wctp_pkg::STEP_W'(wctp_pkg::MUL_STEPS - 1);
            state_q   <= S_MUL_LO;
          end
        end

        S_MUL_LO: begin
          acc_q    <= acc_d;
          mplier_q <= mplier_d;
          step_q   <= step_q - 1'b1;
          if (step_last) begin
            // rem * (rate mod 1e9) is under 2^60
            dvd_q   <= {acc_d[59:0], 4'd0};
            rmd_q   <= '0;
            step_q  <= wctp_pkg::STEP_W'(wctp_pkg::DIV_LO_STEPS - 1);
            state_q <= S_DIV_LO;
          end
        end

        S_DIV_LO: begin
          dvd_q  <= dvd_d;
          rmd_q  <= rmd_d;
          step_q <= step_q - 1'b1;
          if (step_last) begin
            state_q <= S_SUM;
          end
        end

        S_SUM: begin
          frac_q  <= {1'b0, frac_hi_q} + {12'd0, dvd_q[29:0]};
          state_q <= S_TARGET;
        end

        S_TARGET: begin
          target_q <= (whole_sat_q || target_sum[64]) ? '1 : target_sum[63:0];
          state_q  <= S_LAG;
        end

        S_LAG: begin
          lag_q   <= lag_full[63:0];
          ahead_q <= !lag_full[64] && (lag_full[63:0] != '0);
          state_q <= S_GRANT;
        end

        S_GRANT: begin
          // skip-ahead and small lag both land exactly on the target
          if (!ahead_q) begin
            res_q <= '0;
          end else if (over_chunk) begin
            res_q     <= chunk_q;
            emitted_q <= skip_ahead ? target_q : emitted_q + {32'd0, chunk_q};
          end else begin
            res_q     <= lag_q[wctp_pkg::GRANT_W-1:0];
            emitted_q <= target_q;
          end
          state_q <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_grant_q <= res_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.ticks_granted = out_grant_q;

  // a grant never exceeds the chunk in force when it was formed
  a_grant_le_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRANT) |=> (res_q <= $past(chunk_q)))
    else $error("grant above max chunk");

  // the emitted count only moves backward on a start request
  a_emitted_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == S_DECODE && op_q == wctp_pkg::OP_START) |=>
      (emitted_q >= $past(emitted_q)))
    else $error("emitted count decreased");

  // an accepted start clears the emitted count once decoded
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.opcode == wctp_pkg::OP_START) |=>
      ##1 (emitted_q == '0))
    else $error("start did not clear emitted count");

endmodule

`default_nettype wire

// ----- bench/wall_clock_tick_pacer_top_tb.sv -----
// Self-checking testbench for wall_clock_tick_pacer_top: directed and random requests,
// a predictor of the pacing arithmetic, and random stalls on both channels.
// Depends on wctp_pkg and the channel interfaces in wctp_if.sv.
`timescale 1ns / 1ps

module wall_clock_tick_pacer_top_tb;
  import wctp_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
  localparam logic [63:0]      ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [62:0]      NOW_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [127:0]     NS_PER_S     = 128'd1000000000;
  localparam int unsigned      IDLE_LIMIT   = 4000;
  localparam int unsigned      DRAIN_CYCLES = 200;
  localparam int unsigned      REPORT_MAX   = 10;
  localparam int unsigned      RAND_PHASES  = 8;
  localparam int unsigned      PHASE_REQS   = 230;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NOW_W-1:0] now_ns;
    logic [CNT_W-1:0] ticks;
  } pacer_req_t;

  logic clk_i;
  logic rst_ni;

  wctp_req_if req ();
  wctp_rsp_if rsp ();
  wctp_cfg_if cfg ();

  wall_clock_tick_pacer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  pacer_req_t          pending_reqs[$];
  pacer_req_t          req_on_bus;
  logic [GRANT_W-1:0]  grants_due[$];
  logic [GRANT_W-1:0]  grant_want;

  // shadow of the pacer: settings and state
  logic [TPS_W-1:0]    rate_tps;
  logic [CHUNK_W-1:0]  chunk_cap;
  logic [NOW_W-1:0]    start_ns;
  logic [CNT_W-1:0]    ticks_out;

  int unsigned mismatches  = 0;
  int unsigned req_gap     = 0;
  int unsigned rsp_stall   = 0;
  int unsigned idle_cycles = 0;
  bit          src_calm    = 1'b0;
  bit          snk_calm    = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [GRANT_W-1:0] pace_grant(pacer_req_t r);
    logic [127:0]     exact;
    logic [CNT_W-1:0] target;
    logic [CNT_W-1:0] due;
    logic [CNT_W:0]   sum;
    case (r.op)
      OP_START: begin
        start_ns  = r.now_ns;
        ticks_out = '0;
        return '0;
      end
      OP_CREDIT: begin
        sum = {1'b0, ticks_out} + {1'b0, r.ticks};
        ticks_out = sum[CNT_W] ? ALL_ONES : sum[CNT_W-1:0];
        return '0;
      end
      OP_QUERY: begin
        if (rate_tps == '0 || chunk_cap == '0 || r.now_ns <= start_ns) return '0;
        exact  = (128'(r.now_ns - start_ns) * 128'(rate_tps)) / NS_PER_S;
        target = (exact > 128'(ALL_ONES)) ? ALL_ONES : exact[CNT_W-1:0];
        if (target <= ticks_out) return '0;
        // far behind: jump to one chunk short of the target
        if (target - ticks_out >= (64'(chunk_cap) << 2)) ticks_out = target - 64'(chunk_cap);
        due = target - ticks_out;
        if (due > 64'(chunk_cap)) due = 64'(chunk_cap);
        ticks_out = ticks_out + due;
        return due[GRANT_W-1:0];
      end
      default: return '0;
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 39);
    if (roll == 0) return $urandom_range(20, 80);
    if (roll < 9) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_req(logic [OP_W-1:0] op, logic [NOW_W-1:0] now_ns,
                                   logic [CNT_W-1:0] ticks);
    pacer_req_t r;
    r.op     = op;
    r.now_ns = now_ns;
    r.ticks  = ticks;
    pending_reqs.push_back(r);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req.valid && req.ready) begin
        grants_due.push_back(pace_grant(req_on_bus));
        if ($urandom_range(0, 99) == 0) src_calm = ~src_calm;
      end
      if (!req.valid || req.ready) begin
        if (req_gap != 0) begin
          req_gap--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_on_bus = pending_reqs.pop_front();
          req.valid      <= 1'b1;
          req.opcode     <= req_on_bus.op;
          req.now_ns     <= req_on_bus.now_ns;
          req.tick_count <= req_on_bus.ticks;
          req_gap = pick_gap(src_calm);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and ready generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (grants_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected response: ticks_granted %0d", rsp.ticks_granted);
        end else begin
          grant_want = grants_due.pop_front();
          if (rsp.ticks_granted !== grant_want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("ticks_granted mismatch: expected %0d, got %0d",
                       grant_want, rsp.ticks_granted);
          end
        end
      end
      if (rsp_stall != 0) begin
        rsp_stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap(snk_calm);
        if ($urandom_range(0, 999) == 0) snk_calm = ~snk_calm;
      end
    end
  end

  // watchdog: stretch of cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_TPS) rate_tps = value[TPS_W-1:0];
    else chunk_cap = value[CHUNK_W-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req.valid || grants_due.size() != 0);
  endtask

  task automatic random_settings();
    logic [TPS_W-1:0]   r;
    logic [CHUNK_W-1:0] c;
    case ($urandom_range(0, 5))
      0: r = $urandom_range(1, 1000);
      1: r = $urandom_range(1000000, 1000000000);
      2: r = 40'(rand64());
      3: r = '1;
      4: r = 40'd1000000000;
      default: r = 40'(rand64() >> $urandom_range(24, 63));
    endcase
    case ($urandom_range(0, 4))
      0: c = 1;
      1: c = $urandom_range(2, 64);
      2: c = $urandom_range(65, 100000);
      3: c = $urandom;
      default: c = '1;
    endcase
    // pacing off for a whole phase now and then
    if ($urandom_range(0, 9) == 0) c = '0;
    if ($urandom_range(0, 1) == 0) begin
      set_reg(CFG_TPS, r);
      set_reg(CFG_CHUNK, {8'($urandom), c});
    end else begin
      set_reg(CFG_CHUNK, {8'($urandom), c});
      set_reg(CFG_TPS, r);
    end
  endtask

  // one start, then mostly forward-moving queries sized in chunks, a few credits
  task automatic add_session(int unsigned n);
    logic [63:0]      t;
    logic [63:0]      origin;
    logic [127:0]     span;
    logic [CNT_W-1:0] ticks;
    int unsigned      back;
    case ($urandom_range(0, 3))
      0: t = '0;
      1: t = $urandom_range(0, 1000000);
      2: t = rand64() >> (1 + $urandom_range(0, 62));
      default: t = 64'(NOW_MAX) - (rand64() >> $urandom_range(2, 63));
    endcase
    origin = t;
    push_req(OP_START, t[62:0], rand64());
    repeat (n) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          if ($urandom_range(0, 7) == 0) ticks = rand64();
          else ticks = (64'(chunk_cap) * $urandom_range(0, 6)) >> 1;
          push_req(OP_CREDIT, rand64(), ticks);
        end
        2: begin
          back = $urandom_range(0, 3);
          push_req(OP_QUERY, (origin > back) ? origin - back : '0, rand64());
        end
        default: begin
          if (rate_tps == '0 || $urandom_range(0, 4) == 0) begin
            span = rand64() >> $urandom_range(0, 63);
          end else begin
            ticks = 64'(chunk_cap) * $urandom_range(0, 6) + $urandom_range(0, 3);
            span  = (128'(ticks) * NS_PER_S + 128'(rate_tps) - 1) / 128'(rate_tps);
          end
          t = (128'(t) + span > 128'(NOW_MAX)) ? 64'(NOW_MAX) : t + span[63:0];
          push_req(OP_QUERY, t[62:0], rand64());
        end
      endcase
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.opcode     = OP_START;
    req.now_ns     = '0;
    req.tick_count = '0;
    rsp.ready      = 1'b0;
    cfg.valid      = 1'b0;
    cfg.index      = CFG_TPS;
    cfg.data       = '0;
    rate_tps       = '0;
    chunk_cap      = '0;
    start_ns       = '0;
    ticks_out      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // settings at reset: pacing off
    push_req(OP_START, 63'd500, '0);
    push_req(OP_QUERY, 63'd1000, '0);
    push_req(OP_CREDIT, '0, 64'd7);
    push_req(OP_UNUSED, NOW_MAX, ALL_ONES);
    wait_idle();

    // one tick per ns, chunk of 100; upper data bits must be dropped
    set_reg(CFG_TPS, 40'd1000000000);
    set_reg(CFG_CHUNK, {8'hFF, 32'd100});
    push_req(OP_START, 63'd1000, '0);
    push_req(OP_QUERY, 63'd1000, '0);
    push_req(OP_QUERY, 63'd999, '0);
    push_req(OP_QUERY, 63'd1050, '0);
    push_req(OP_QUERY, 63'd1050, '0);
    push_req(OP_CREDIT, '0, '0);
    push_req(OP_CREDIT, '0, 64'd30);
    push_req(OP_QUERY, 63'd1100, '0);
    push_req(OP_QUERY, 63'd10000, '0);
    push_req(OP_CREDIT, '0, ALL_ONES);
    push_req(OP_QUERY, NOW_MAX, '0);
    push_req(OP_START, '0, '0);
    push_req(OP_QUERY, NOW_MAX, '0);
    wait_idle();

    // widest rate and chunk: target saturates
    set_reg(CFG_TPS, '1);
    set_reg(CFG_CHUNK, '1);
    push_req(OP_START, '0, '0);
    push_req(OP_QUERY, NOW_MAX, '0);
    push_req(OP_QUERY, NOW_MAX, '0);
    push_req(OP_CREDIT, NOW_MAX, ALL_ONES);
    wait_idle();

    // slowest rate, smallest chunk: lag of exactly four chunks skips
    set_reg(CFG_TPS, 40'd1);
    set_reg(CFG_CHUNK, 40'd1);
    push_req(OP_START, '0, '0);
    push_req(OP_QUERY, 63'd1000000000, '0);
    push_req(OP_QUERY, 63'd5000000000, '0);
    wait_idle();

    set_reg(CFG_TPS, '0);
    set_reg(CFG_CHUNK, 40'd5);
    push_req(OP_QUERY, 63'd1000000000000, '0);
    wait_idle();
    set_reg(CFG_TPS, 40'd1000);
    set_reg(CFG_CHUNK, '0);
    push_req(OP_QUERY, 63'd1000000000000, '0);
    wait_idle();

    repeat (RAND_PHASES) begin
      random_settings();
      n = 0;
      while (n < PHASE_REQS) begin
        if ($urandom_range(0, 6) == 0) begin
          push_req($urandom_range(0, 3), rand64(), rand64());
          n++;
        end else begin
          k = $urandom_range(3, 40);
          add_session(k);
          n += k + 1;
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- wall_clock_tick_pacer_top.f -----
rtl/wctp_pkg.sv
rtl/wctp_if.sv
rtl/wall_clock_tick_pacer_top.sv
bench/wall_clock_tick_pacer_top_tb.sv
